// ----- src/fobp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and the saturation helper for the fourth-order band-pass IIR.
// Used by the channel interfaces and by the top level; depends on nothing else.

package fobp_pkg;

	// Default widths, handed down through the top-level parameters.
	localparam int SAMPLE_WIDTH_DEF   = 24;
	localparam int COEF_FRAC_BITS_DEF = 28;

	// Fixed datapath widths.
	localparam int COEF_W    = 32;
	localparam int STATE_W   = 56;
	localparam int PROD_W    = 60;
	localparam int WIDE_W    = 64;
	localparam int CFG_IDX_W = 3;
	localparam int MODE_W    = 2;
	localparam int NUM_FB    = 4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_MODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_A1   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_A2   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_A3   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_A4   = 3'd5;

	// Filter mode codes; the unused code behaves as MODE_ZERO.
	localparam logic [MODE_W-1:0] MODE_ZERO   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FILTER = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PASS   = 2'd2;

	// Reset value of the numerator gain: 1.0 in Q4.28.
	localparam logic signed [COEF_W-1:0] GAIN_RESET = 32'sd268435456;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ROUND,
		ST_FEED,
		ST_LAST,
		ST_HOLD
	} fobp_state_t;

	// Saturated value together with its overflow flag.
	typedef struct packed {
		logic signed [WIDE_W-1:0] value;
		logic                     clip;
	} sat_t;

	// Clamp a wide signed value into the range of a w-bit two's complement number.
	function automatic sat_t sat_to(input logic signed [WIDE_W-1:0] v, input int unsigned w);
		logic signed [WIDE_W-1:0] hi;
		logic signed [WIDE_W-1:0] lo;
		sat_t r;
		hi = (64'sd1 <<< (w - 1)) - 64'sd1;
		lo = -hi - 64'sd1;
		r.value = v;
		r.clip = 1'b0;
		if (v > hi) begin
			r.value = hi;
			r.clip = 1'b1;
		end else if (v < lo) begin
			r.value = lo;
			r.clip = 1'b1;
		end
		return r;
	endfunction

endpackage

// ----- src/fobp_in_if.sv -----
`timescale 1ns / 1ps
// Input sample channel: valid/ready handshake carrying one sample and its block-start mark.
// Depends on fobp_pkg for the default sample width.

interface fobp_in_if import fobp_pkg::*; #(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_in;
	logic                           block_start;

	modport source (output valid, output sample_in, output block_start, input ready);
	modport sink (input valid, input sample_in, input block_start, output ready);
endinterface

// ----- src/fobp_out_if.sv -----
`timescale 1ns / 1ps
// Output sample channel: valid/ready handshake carrying one filtered sample and its clip flag.
// Depends on fobp_pkg for the default sample width.

interface fobp_out_if import fobp_pkg::*; #(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_out;
	logic                           clipped;

	modport source (output valid, output sample_out, output clipped, input ready);
	modport sink (input valid, input sample_out, input clipped, output ready);
endinterface

// ----- src/fobp_cfg_if.sv -----
`timescale 1ns / 1ps
// Configuration write channel: valid/ready handshake carrying a register index and data.
// Depends on fobp_pkg for the index and data widths.

interface fobp_cfg_if import fobp_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [COEF_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/fourth_order_band_pass_iir_unit.sv -----
`timescale 1ns / 1ps
// Fourth-order band-pass IIR in transposed direct form II, built round one shared multiplier.
// Depends on fobp_pkg and the channel interfaces fobp_in_if, fobp_out_if and fobp_cfg_if.
//
//   channel | direction | payload                      | accepted when
//   din     | in        | sample_in, block_start       | din.valid & din.ready
//   dout    | out       | sample_out, clipped          | dout.valid & dout.ready
//   cfg     | in        | index, data                  | cfg.valid & cfg.ready
//
// A filtered item runs from acceptance to the output stage as one multiply for the
// numerator, one round step, then four feedback multiplies on the same multiplier,
// with each delay register updated in the cycle after its product.
// Zero and pass-through items go straight to the output stage. One item is in flight at a time.
// A result waits in the output register; the next item is not taken until it has moved there.
// Reset clears the delay line and loads the register defaults; cfg is always ready.

module fourth_order_band_pass_iir_unit import fobp_pkg::*; #(
	parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	fobp_in_if.sink   din,
	fobp_out_if.source dout,
	fobp_cfg_if.sink  cfg
);

	localparam int MUL_W = COEF_W + SAMPLE_WIDTH;

	// Sequencer and configuration registers.
	fobp_state_t state_q, state_d;
	logic [MODE_W-1:0]        mode_q;
	logic signed [COEF_W-1:0] gain_q;
	logic signed [COEF_W-1:0] fb_q [NUM_FB];
	logic [1:0]               cnt_q;

	// Datapath registers.
	logic signed [STATE_W-1:0]      line_q [NUM_FB];
	logic signed [SAMPLE_WIDTH-1:0] x_q;
	logic signed [SAMPLE_WIDTH-1:0] y_q;
	logic signed [PROD_W-1:0]       p_q;
	logic signed [MUL_W-1:0]        prod_q;
	logic                           clip_q;

	// Output register.
	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] sample_out_q;
	logic                           clipped_q;

	// Combinational signals.
	logic                           accept;
	logic                           out_load;
	logic signed [COEF_W-1:0]       mul_a;
	logic signed [SAMPLE_WIDTH-1:0] mul_b;
	logic [1:0]                     upd_step;
	logic signed [WIDE_W-1:0]       prod_ext;
	logic signed [WIDE_W-1:0]       acc;
	logic signed [WIDE_W-1:0]       biased;
	logic signed [WIDE_W-1:0]       y_full;
	logic signed [WIDE_W-1:0]       upd_base;
	logic signed [WIDE_W-1:0]       upd_twop;
	logic signed [WIDE_W-1:0]       upd_diff;
	sat_t                           prod_sat;
	sat_t                           y_sat;
	sat_t                           s_sat;

	assign accept     = din.valid & din.ready;
	assign cfg.ready  = 1'b1;
	assign dout.valid = out_valid_q;
	assign dout.sample_out = sample_out_q;
	assign dout.clipped    = clipped_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, input ready and output load.
	always_comb begin
		state_d  = state_q;
		din.ready = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				din.ready = 1'b1;
				if (din.valid) begin
					state_d = (mode_q == MODE_FILTER) ? ST_MUL : ST_HOLD;
				end
			end
			ST_MUL:   state_d = ST_ROUND;
			ST_ROUND: state_d = ST_FEED;
			ST_FEED: begin
				if (cnt_q == 2'(NUM_FB - 1)) begin
					state_d = ST_LAST;
				end
			end
			ST_LAST:  state_d = ST_HOLD;
			ST_HOLD: begin
				if (!out_valid_q || dout.ready) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// Configuration registers; writes are expected only while no item is in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ZERO;
			gain_q <= GAIN_RESET;
			for (int i = 0; i < NUM_FB; i++) begin
				fb_q[i] <= '0;
			end
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_MODE: mode_q <= cfg.data[MODE_W-1:0];
				REG_GAIN: gain_q <= cfg.data;
				REG_A1:   fb_q[0] <= cfg.data;
				REG_A2:   fb_q[1] <= cfg.data;
				REG_A3:   fb_q[2] <= cfg.data;
				REG_A4:   fb_q[3] <= cfg.data;
				default:  ;
			endcase
		end
	end

	// Shared multiplier operands: gain times sample first, then a1..a4 times the output.
	assign mul_a    = (state_q == ST_MUL) ? gain_q : fb_q[cnt_q];
	assign mul_b    = (state_q == ST_MUL) ? x_q : y_q;
	assign prod_ext = WIDE_W'(prod_q);
	assign prod_sat = sat_to(prod_ext, PROD_W);

	// Rounding of the accumulator and the delay register update.
	always_comb begin
		acc    = prod_sat.value + WIDE_W'(line_q[0]);
		biased = acc + (64'sd1 <<< (COEF_FRAC_BITS - 1));
		y_full = biased >>> COEF_FRAC_BITS;
		y_sat  = sat_to(y_full, SAMPLE_WIDTH);

		upd_step = (state_q == ST_LAST) ? 2'(NUM_FB - 1) : cnt_q - 2'd1;
		upd_base = (upd_step == 2'(NUM_FB - 1)) ? WIDE_W'(p_q) : WIDE_W'(line_q[0]);
		upd_twop = (upd_step == 2'd1) ? (WIDE_W'(p_q) <<< 1) : '0;
		upd_diff = upd_base - upd_twop - prod_sat.value;
		s_sat    = sat_to(upd_diff, STATE_W);
	end

	// Delay line: the next register to read always sits at the head, new values enter at the tail.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_FB; i++) begin
				line_q[i] <= '0;
			end
		end else if (accept && din.block_start) begin
			for (int i = 0; i < NUM_FB; i++) begin
				line_q[i] <= '0;
			end
		end else if (state_q == ST_ROUND) begin
			for (int i = 0; i < NUM_FB - 1; i++) begin
				line_q[i] <= line_q[i+1];
			end
			line_q[NUM_FB-1] <= line_q[0];
		end else if ((state_q == ST_FEED && cnt_q != 2'd0) || state_q == ST_LAST) begin
			for (int i = 0; i < NUM_FB - 1; i++) begin
				line_q[i] <= line_q[i+1];
			end
			line_q[NUM_FB-1] <= s_sat.value[STATE_W-1:0];
		end
	end

	// Sample, product, output sample and clip flag of the item in flight.
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q    <= din.sample_in;
			clip_q <= 1'b0;
			y_q    <= (mode_q == MODE_PASS) ? din.sample_in : '0;
		end
		if (state_q == ST_MUL || state_q == ST_FEED) begin
			prod_q <= mul_a * mul_b;
		end
		if (state_q == ST_ROUND) begin
			p_q    <= prod_sat.value[PROD_W-1:0];
			y_q    <= y_sat.value[SAMPLE_WIDTH-1:0];
			clip_q <= prod_sat.clip | y_sat.clip;
		end else if ((state_q == ST_FEED && cnt_q != 2'd0) || state_q == ST_LAST) begin
			clip_q <= clip_q | prod_sat.clip | s_sat.clip;
		end
	end

	// Feedback step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == ST_ROUND) begin
			cnt_q <= '0;
		end else if (state_q == ST_FEED) begin
			cnt_q <= cnt_q + 2'd1;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			sample_out_q <= y_q;
			clipped_q    <= clip_q;
		end
	end

`ifndef SYNTHESIS
	// A zero or pass-through item goes straight to the output stage.
	a_short_path: assert property (@(posedge clk) disable iff (!arst_n)
		accept && mode_q != MODE_FILTER |=> state_q == ST_HOLD)
		else $error("non-filter item did not reach the output stage");

	// A filtered item reaches the output stage after its multiply, round and feedback steps.
	a_filter_len: assert property (@(posedge clk) disable iff (!arst_n)
		accept && mode_q == MODE_FILTER |-> ##8 state_q == ST_HOLD)
		else $error("filtered item did not reach the output stage in eight cycles");

	// A result is held back while the output register is full and stalled.
	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_HOLD && out_valid_q && !dout.ready |=> state_q == ST_HOLD)
		else $error("result left the output stage while the output was stalled");

	// Only the filtering mode can report clipping.
	a_clip_mode: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && dout.clipped |-> mode_q == MODE_FILTER)
		else $error("clip flag raised outside filtering mode");
`endif

endmodule

// ----- dv/fourth_order_band_pass_iir_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the fourth-order band-pass IIR unit, with its own bit-exact predictor.
// Depends on fobp_pkg, the channel interfaces fobp_in_if, fobp_out_if and fobp_cfg_if, and the unit.

module fourth_order_band_pass_iir_unit_tb import fobp_pkg::*; ;

	localparam int SW   = SAMPLE_WIDTH_DEF;
	localparam int FRAC = COEF_FRAC_BITS_DEF;

	localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
	localparam logic [MODE_W-1:0]    MODE_UNUSED = 2'd3;

	localparam logic [COEF_W-1:0] COEF_MAX = 32'h7FFF_FFFF;
	localparam logic [COEF_W-1:0] COEF_MIN = 32'h8000_0000;

	// A wide stable band-pass: poles at radius 0.9, angles 1.2 and 1.4 rad.
	localparam logic [COEF_W-1:0] WIDE_GAIN = 32'sd13421773;
	localparam logic [COEF_W-1:0] WIDE_A1   = -32'sd257228276;
	localparam logic [COEF_W-1:0] WIDE_A2   = 32'sd488437103;
	localparam logic [COEF_W-1:0] WIDE_A3   = -32'sd208354232;
	localparam logic [COEF_W-1:0] WIDE_A4   = 32'sd176120503;

	// A narrow, high-Q band-pass: poles at radius 0.95, angles 0.3 and 0.4 rad.
	localparam logic [COEF_W-1:0] NARROW_GAIN = 32'sd536871;
	localparam logic [COEF_W-1:0] NARROW_A1   = -32'sd957012666;
	localparam logic [COEF_W-1:0] NARROW_A2   = 32'sd1337216593;
	localparam logic [COEF_W-1:0] NARROW_A3   = -32'sd863704502;
	localparam logic [COEF_W-1:0] NARROW_A4   = 32'sd218643364;

	typedef struct {
		logic signed [SW-1:0] sample;
		logic                 clip;
	} filt_result_t;

	logic clk;
	logic arst_n;

	fobp_in_if #(.SAMPLE_WIDTH(SW)) din_bus ();
	fobp_out_if #(.SAMPLE_WIDTH(SW)) dout_bus ();
	fobp_cfg_if cfg_bus ();

	fourth_order_band_pass_iir_unit #(
		.SAMPLE_WIDTH(SW),
		.COEF_FRAC_BITS(FRAC)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.din(din_bus),
		.dout(dout_bus),
		.cfg(cfg_bus)
	);

	// Predictor copy of the configuration and the delay line.
	logic [MODE_W-1:0] cur_mode = MODE_ZERO;
	longint            cur_gain = longint'(GAIN_RESET);
	longint            fb_coef [NUM_FB] = '{default: 0};
	longint            delay_line [NUM_FB] = '{default: 0};

	filt_result_t due_samples [$];
	filt_result_t head_result;
	int           failures = 0;

	int src_idle_pct  = 32;
	int sink_idle_pct = 32;
	int hold_request  = 0;
	int hold_left     = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Clamp a value into the w-bit signed range, noting any saturation.
	function automatic longint clamp_signed(input longint v, input int w, inout bit sat);
		longint top;
		top = (longint'(1) <<< (w - 1)) - 1;
		if (v > top) begin
			sat = 1'b1;
			return top;
		end
		if (v < -top - 1) begin
			sat = 1'b1;
			return -top - 1;
		end
		return v;
	endfunction

	// Work out the result of one item and advance the predicted delay line.
	function automatic void filter_predict(input logic signed [SW-1:0] x, input logic start,
			output logic signed [SW-1:0] y_out, output logic clip_out);
		longint xs, prod, acc, y;
		longint fb_prod [NUM_FB];
		longint nxt [NUM_FB];
		bit sat;
		sat = 1'b0;
		xs = x;
		if (start) begin
			for (int i = 0; i < NUM_FB; i++) delay_line[i] = 0;
		end
		if (cur_mode == MODE_PASS) begin
			y_out = x;
			clip_out = 1'b0;
			return;
		end
		if (cur_mode != MODE_FILTER) begin
			y_out = '0;
			clip_out = 1'b0;
			return;
		end
		prod = clamp_signed(cur_gain * xs, PROD_W, sat);
		acc = prod + delay_line[0];
		// Round half up, then drop the fraction bits with an arithmetic shift.
		y = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
		y = clamp_signed(y, SW, sat);
		for (int i = 0; i < NUM_FB; i++) fb_prod[i] = clamp_signed(fb_coef[i] * y, PROD_W, sat);
		nxt[0] = clamp_signed(delay_line[1] - fb_prod[0], STATE_W, sat);
		nxt[1] = clamp_signed(delay_line[2] - 2 * prod - fb_prod[1], STATE_W, sat);
		nxt[2] = clamp_signed(delay_line[3] - fb_prod[2], STATE_W, sat);
		nxt[3] = clamp_signed(prod - fb_prod[3], STATE_W, sat);
		delay_line = nxt;
		y_out = SW'(y);
		clip_out = sat;
	endfunction

	// Lower the input valid and wait until every predicted result has been seen.
	task automatic drain_results();
		@(negedge clk);
		din_bus.valid <= 1'b0;
		while (due_samples.size() != 0) @(posedge clk);
	endtask

	// Offer one item, wait for its acceptance and store its predicted result.
	task automatic send_sample(input logic signed [SW-1:0] x, input logic start);
		logic signed [SW-1:0] y;
		logic clip;
		int gap;
		filt_result_t pred;
		gap = 0;
		if (src_idle_pct != 0 && $urandom_range(15) == 0) gap = $urandom_range(10, 1);
		@(negedge clk);
		while (gap != 0 || $urandom_range(99) < src_idle_pct) begin
			din_bus.valid <= 1'b0;
			if (gap != 0) gap--;
			@(negedge clk);
		end
		din_bus.valid <= 1'b1;
		din_bus.sample_in <= x;
		din_bus.block_start <= start;
		do @(posedge clk); while (!din_bus.ready);
		filter_predict(x, start, y, clip);
		pred.sample = y;
		pred.clip = clip;
		due_samples.insert(due_samples.size(), pred);
	endtask

	// Write one register once the unit has gone idle.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] value);
		drain_results();
		@(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= value;
		do @(posedge clk); while (!cfg_bus.ready);
		case (idx)
			REG_MODE: cur_mode = value[MODE_W-1:0];
			REG_GAIN: cur_gain = longint'($signed(value));
			REG_A1:   fb_coef[0] = longint'($signed(value));
			REG_A2:   fb_coef[1] = longint'($signed(value));
			REG_A3:   fb_coef[2] = longint'($signed(value));
			REG_A4:   fb_coef[3] = longint'($signed(value));
			default: ;
		endcase
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic load_coefficients(input logic [COEF_W-1:0] g, input logic [COEF_W-1:0] c1,
			input logic [COEF_W-1:0] c2, input logic [COEF_W-1:0] c3,
			input logic [COEF_W-1:0] c4);
		write_reg(REG_GAIN, g);
		write_reg(REG_A1, c1);
		write_reg(REG_A2, c2);
		write_reg(REG_A3, c3);
		write_reg(REG_A4, c4);
	endtask

	// Samples weighted towards the extremes and towards small values.
	function automatic logic signed [SW-1:0] pick_sample();
		case ($urandom_range(9))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2: return $urandom_range(1) ? '0 : '1;
			3, 4: return SW'(int'($urandom_range(8191)) - 4096);
			default: return SW'($urandom());
		endcase
	endfunction

	function automatic logic [COEF_W-1:0] pick_coef();
		case ($urandom_range(7))
			0: return COEF_MAX;
			1: return COEF_MIN;
			2: return '0;
			3, 4: return $urandom();
			default: return 32'(int'($urandom_range(536870911)) - 268435456);
		endcase
	endfunction

	// Items grouped into blocks that open with a start mark, with the odd mark misplaced.
	task automatic send_blocks(input int n_items);
		int sent;
		int run_len;
		logic start;
		sent = 0;
		while (sent < n_items) begin
			run_len = $urandom_range(64, 1);
			for (int k = 0; k < run_len && sent < n_items; k++) begin
				start = (k == 0);
				if ($urandom_range(19) == 0) start = ~start;
				send_sample(pick_sample(), start);
				sent++;
			end
		end
	endtask

	// After reset the unit outputs zero, with unity gain and no feedback behind it.
	task automatic test_reset_defaults();
		send_sample(SAMPLE_MAX, 1'b0);
		send_sample(SAMPLE_MIN, 1'b1);
		write_reg(REG_MODE, 32'(MODE_FILTER));
		send_sample(SAMPLE_MAX, 1'b0);
		send_sample(SAMPLE_MIN, 1'b0);
		send_sample('1, 1'b0);
		send_sample(SW'(1), 1'b0);
	endtask

	// Pass-through, the unused code and the zero mode; upper data bits are ignored.
	task automatic test_mode_codes();
		write_reg(REG_MODE, {30'h3FFF_FFFF, MODE_PASS});
		send_sample(SAMPLE_MIN, 1'b0);
		send_sample(SAMPLE_MAX, 1'b1);
		write_reg(REG_MODE, 32'(MODE_UNUSED));
		send_sample(SW'(12345), 1'b0);
		send_sample(SAMPLE_MAX, 1'b0);
		write_reg(REG_MODE, 32'(MODE_ZERO));
		send_sample(-SW'(5), 1'b1);
	endtask

	// Impulse response of a real band-pass, then extreme coefficients that saturate.
	task automatic test_band_pass_directed();
		load_coefficients(WIDE_GAIN, WIDE_A1, WIDE_A2, WIDE_A3, WIDE_A4);
		write_reg(REG_MODE, 32'(MODE_FILTER));
		send_sample(SAMPLE_MAX, 1'b1);
		send_sample('0, 1'b0);
		send_sample('0, 1'b0);
		send_sample('0, 1'b0);
		send_sample(SAMPLE_MIN, 1'b0);
		load_coefficients(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX);
		send_sample(SAMPLE_MAX, 1'b1);
		send_sample(SAMPLE_MIN, 1'b0);
		send_sample(SAMPLE_MAX, 1'b0);
		send_sample(SAMPLE_MIN, 1'b0);
	endtask

	// The delay line survives the other modes, but a start mark clears it in any mode.
	task automatic test_block_start_clears();
		load_coefficients(WIDE_GAIN, WIDE_A1, WIDE_A2, WIDE_A3, WIDE_A4);
		send_sample(SW'(1000000), 1'b1);
		send_sample(SW'(2000000), 1'b0);
		write_reg(REG_MODE, 32'(MODE_PASS));
		send_sample(SW'(7), 1'b0);
		write_reg(REG_MODE, 32'(MODE_FILTER));
		send_sample('0, 1'b0);
		write_reg(REG_MODE, 32'(MODE_ZERO));
		send_sample(SW'(3), 1'b1);
		write_reg(REG_MODE, 32'(MODE_FILTER));
		send_sample('0, 1'b0);
	endtask

	// Stable filters with random gains; one phase without idling, one under back-pressure.
	task automatic test_random_band_pass();
		for (int ph = 0; ph < 4; ph++) begin
			if (ph % 2 == 0)
				load_coefficients(32'($urandom_range(1 << 26)), WIDE_A1, WIDE_A2, WIDE_A3,
					WIDE_A4);
			else
				load_coefficients(NARROW_GAIN + 32'($urandom_range(1 << 20)), NARROW_A1,
					NARROW_A2, NARROW_A3, NARROW_A4);
			write_reg(REG_MODE, 32'(MODE_FILTER));
			if (ph == 1) begin
				src_idle_pct = 0;
				sink_idle_pct = 0;
				send_blocks(150);
			end else if (ph == 2) begin
				// The receiver stalls long enough for the unit to fill and hold its input.
				hold_request = 300;
				send_blocks(75);
				drain_results();
				send_blocks(75);
			end else begin
				send_blocks(150);
			end
			drain_results();
			src_idle_pct = 32;
			sink_idle_pct = 32;
		end
	endtask

	// Arbitrary coefficients and modes, which mostly run into saturation.
	task automatic test_random_coefficients();
		logic [MODE_W-1:0] mode;
		for (int ph = 0; ph < 4; ph++) begin
			load_coefficients(pick_coef(), pick_coef(), pick_coef(), pick_coef(), pick_coef());
			mode = ($urandom_range(9) < 7) ? MODE_FILTER : MODE_W'($urandom_range(3));
			write_reg(REG_MODE, {30'($urandom()), mode});
			send_blocks(140);
		end
	endtask

	// Receiver: random stalls, or a counted hold-off when one is requested.
	initial begin
		dout_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				dout_bus.ready <= 1'b0;
			end else begin
				dout_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	// Compare each result item with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && dout_bus.valid && dout_bus.ready) begin
			if (due_samples.size() == 0) begin
				$error("unexpected result item: sample_out %0d, clipped %0b",
					dout_bus.sample_out, dout_bus.clipped);
				failures++;
			end else begin
				head_result = due_samples.pop_front();
				if (dout_bus.sample_out !== head_result.sample) begin
					$error("sample_out mismatch: expected %0d, got %0d",
						head_result.sample, dout_bus.sample_out);
					failures++;
				end
				if (dout_bus.clipped !== head_result.clip) begin
					$error("clipped mismatch: expected %0b, got %0b",
						head_result.clip, dout_bus.clipped);
					failures++;
				end
			end
		end
	end

	// Main sequence.
	initial begin
		arst_n = 1'b0;
		din_bus.valid = 1'b0;
		din_bus.sample_in = '0;
		din_bus.block_start = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = '0;
		cfg_bus.data = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_mode_codes();
		test_band_pass_directed();
		test_block_start_clears();
		test_random_band_pass();
		test_random_coefficients();

		drain_results();
		repeat (16) @(posedge clk);
		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
